@@ hdl/yaz0sd_pkg.sv @@
// yaz0sd_pkg: shared types, constants and helpers for the yaz0 stream decompressor
// used by the front parser, the command fifo, the back end and the top level
// no dependencies
package yaz0sd_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int OUT_LANES_DEF     = 8;
    localparam int CMD_FIFO_DEPTH    = 4;
    localparam int HEADER_LAST       = 15;
    localparam int LEN_SHORT_BIAS    = 2;
    localparam int LEN_LONG_BIAS     = 'h12;

    localparam logic [0:0] REG_SKIP_COUNT = 1'b0;
    localparam logic [0:0] REG_MAX_OUT    = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CODE,
        PH_LIT,
        PH_M1,
        PH_M2,
        PH_EXT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_BAD,
        CMD_LIT,
        CMD_COPY
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD,
        BK_WR
    } back_state_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic [11:0] distance;
        logic [8:0]  len;
        logic [31:0] target;
    } cmd_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h59;
            2'd1: b = 8'h61;
            2'd2: b = 8'h7a;
            default: b = 8'h30;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/yaz0_stream_decompressor_unit.sv @@
// yaz0_stream_decompressor_unit: top level, config registers and the three pipeline parts
// depends on yaz0sd_pkg, yaz0sd_front, yaz0sd_cmd_fifo, yaz0sd_back
//
// Yaz0 decompressor fed one compressed byte per transfer. The parser takes a byte
// whenever its small command queue has room. The back end takes one command at a
// time, writes a literal byte into the history, and handles each copied byte as a
// history read, then write and pack; long copies fill the queue and push back on
// the input. Results carry up to OUT_LANES bytes from one input byte.
// The history ring has no clearing pass; references to unwritten entries are undefined.
module yaz0_stream_decompressor_unit #(
    parameter int HISTORY_DEPTH = yaz0sd_pkg::HISTORY_DEPTH_DEF,
    parameter int OUT_LANES     = yaz0sd_pkg::OUT_LANES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        stream_start,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] out_data,
    output logic [3:0]  out_count,
    output logic        run_last,
    output logic        stream_done,
    output logic        bad_magic,
    output logic [31:0] written_total,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import yaz0sd_pkg::*;

    logic [31:0] skip_reg, skip_next;
    logic [31:0] max_out_reg, max_out_next;
    logic        accept;
    logic        cmd_push;
    cmd_t        wr_cmd;
    cmd_t        q_cmd;
    logic        q_empty;
    logic        q_pop;

    assign accept = push && !full;

    always_comb begin
        skip_next    = skip_reg;
        max_out_next = max_out_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_SKIP_COUNT: skip_next    = cfg_data;
                default:        max_out_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            skip_reg    <= 32'd0;
            max_out_reg <= 32'hffff_ffff;
        end
        else begin
            skip_reg    <= skip_next;
            max_out_reg <= max_out_next;
        end
    end

    yaz0sd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .in_byte      (in_byte),
        .stream_start (stream_start),
        .skip_count   (skip_reg),
        .max_out      (max_out_reg),
        .cmd_push     (cmd_push),
        .cmd          (wr_cmd)
    );

    yaz0sd_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cmd_push),
        .wr_cmd (wr_cmd),
        .full   (full),
        .pop    (q_pop),
        .rd_cmd (q_cmd),
        .empty  (q_empty)
    );

    yaz0sd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .OUT_LANES     (OUT_LANES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .skip_count    (skip_reg),
        .q_cmd         (q_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .out_data      (out_data),
        .out_count     (out_count),
        .run_last      (run_last),
        .stream_done   (stream_done),
        .bad_magic     (bad_magic),
        .written_total (written_total)
    );

endmodule

@@ hdl/yaz0sd_front.sv @@
// yaz0sd_front: header check and code-byte parser, turns stream bytes into commands
// depends on yaz0sd_pkg
module yaz0sd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                stream_start,
    input  logic [31:0]         skip_count,
    input  logic [31:0]         max_out,
    output logic                cmd_push,
    output yaz0sd_pkg::cmd_t    cmd
);
    import yaz0sd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [31:0] dlen_reg, dlen_next;
    logic [7:0]  code_reg, code_next;
    logic [3:0]  left_reg, left_next;
    logic [11:0] dist_reg, dist_next;
    logic [3:0]  nib_reg, nib_next;

    phase_t      ph;
    logic [3:0]  hidx;
    logic [31:0] dlen;
    logic [31:0] tgt_sub;
    logic [31:0] tgt;
    logic [7:0]  code_sh;
    logic [3:0]  left_dec;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_HEADER;
            hidx_reg  <= '0;
            dlen_reg  <= '0;
            code_reg  <= '0;
            left_reg  <= '0;
            dist_reg  <= '0;
            nib_reg   <= '0;
        end
        else begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            dlen_reg  <= dlen_next;
            code_reg  <= code_next;
            left_reg  <= left_next;
            dist_reg  <= dist_next;
            nib_reg   <= nib_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        dlen_next  = dlen_reg;
        code_next  = code_reg;
        left_next  = left_reg;
        dist_next  = dist_reg;
        nib_next   = nib_reg;
        cmd_push   = 1'b0;
        cmd        = '0;
        cmd.kind   = CMD_LIT;
        ph   = stream_start ? PH_HEADER : phase_reg;
        hidx = stream_start ? 4'd0 : hidx_reg;
        dlen = stream_start ? 32'd0 : dlen_reg;
        tgt_sub = (dlen > skip_count) ? dlen - skip_count : 32'd0;
        tgt     = (tgt_sub > max_out) ? max_out : tgt_sub;
        // advance to the next flag of the code byte
        code_sh  = {code_reg[6:0], 1'b0};
        left_dec = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
        if (in_valid) begin
            hidx_next = hidx;
            dlen_next = dlen;
            phase_next = ph;
            unique case (ph)
                PH_HEADER: begin
                    if (hidx < 4'd4 && in_byte != magic_byte(hidx[1:0])) begin
                        phase_next = PH_DONE;
                        cmd_push   = 1'b1;
                        cmd.kind   = CMD_BAD;
                    end
                    else begin
                        if (hidx >= 4'd4 && hidx < 4'd8)
                            dlen_next = {dlen[23:0], in_byte};
                        if (hidx == 4'(HEADER_LAST)) begin
                            cmd_push   = 1'b1;
                            cmd.kind   = CMD_START;
                            cmd.target = tgt;
                            phase_next = (tgt == 32'd0) ? PH_DONE : PH_CODE;
                        end
                        else
                            hidx_next = hidx + 4'd1;
                    end
                end
                PH_CODE: begin
                    code_next  = in_byte;
                    left_next  = 4'd8;
                    phase_next = in_byte[7] ? PH_LIT : PH_M1;
                end
                PH_LIT, PH_M2, PH_EXT: begin
                    if (ph == PH_M2 && in_byte[7:0] != 8'd0 && nib_reg == 4'd0) begin
                        dist_next  = {dist_reg[11:8], in_byte};
                        phase_next = PH_EXT;
                    end
                    else if (ph == PH_M2 && nib_reg == 4'd0) begin
                        dist_next  = {dist_reg[11:8], in_byte};
                        phase_next = PH_EXT;
                    end
                    else begin
                        cmd_push  = 1'b1;
                        cmd.data  = in_byte;
                        cmd.distance = dist_reg;
                        if (ph == PH_LIT) begin
                            cmd.kind = CMD_LIT;
                            cmd.len  = 9'd1;
                        end
                        else if (ph == PH_M2) begin
                            cmd.kind = CMD_COPY;
                            cmd.distance = {dist_reg[11:8], in_byte};
                            cmd.len  = 9'(nib_reg) + 9'(LEN_SHORT_BIAS);
                            dist_next = {dist_reg[11:8], in_byte};
                        end
                        else begin
                            cmd.kind = CMD_COPY;
                            cmd.len  = 9'(in_byte) + 9'(LEN_LONG_BIAS);
                        end
                        code_next  = code_sh;
                        left_next  = left_dec;
                        phase_next = (left_dec == 4'd0) ? PH_CODE
                                   : (code_sh[7] ? PH_LIT : PH_M1);
                    end
                end
                PH_M1: begin
                    nib_next   = in_byte[7:4];
                    dist_next  = {in_byte[3:0], 8'd0};
                    phase_next = PH_M2;
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
            if (stream_start) begin
                code_next = (ph == PH_CODE) ? code_next : 8'd0;
                left_next = 4'd0;
                dist_next = 12'd0;
                nib_next  = 4'd0;
            end
        end
    end

endmodule

@@ hdl/yaz0sd_cmd_fifo.sv @@
// yaz0sd_cmd_fifo: short command queue between the parser and the back end
// depends on yaz0sd_pkg
module yaz0sd_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  yaz0sd_pkg::cmd_t wr_cmd,
    output logic             full,
    input  logic             pop,
    output yaz0sd_pkg::cmd_t rd_cmd,
    output logic             empty
);
    import yaz0sd_pkg::*;

    localparam int AW = $clog2(CMD_FIFO_DEPTH);

    cmd_t          slot_reg [CMD_FIFO_DEPTH];
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == (AW+1)'(CMD_FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = slot_reg[rp_reg];

    always_comb begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push)
            slot_reg[wp_reg] <= wr_cmd;
    end

endmodule

@@ hdl/yaz0sd_back.sv @@
// yaz0sd_back: executes literal and copy commands through the history ring, packs results
// depends on yaz0sd_pkg
module yaz0sd_back #(
    parameter int HISTORY_DEPTH = yaz0sd_pkg::HISTORY_DEPTH_DEF,
    parameter int OUT_LANES     = yaz0sd_pkg::OUT_LANES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      skip_count,
    input  yaz0sd_pkg::cmd_t q_cmd,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [63:0]      out_data,
    output logic [3:0]       out_count,
    output logic             run_last,
    output logic             stream_done,
    output logic             bad_magic,
    output logic [31:0]      written_total
);
    import yaz0sd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PW = 8 * OUT_LANES;
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_P  = AW'(HISTORY_DEPTH - 1);
    localparam logic [3:0]    LANES_C = 4'(OUT_LANES);

    logic [7:0] hist_mem [HISTORY_DEPTH];
    logic [7:0] rd_data_reg;

    back_state_t state_reg, state_next;
    logic          fin_reg, fin_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] src_reg, src_next;
    logic [8:0]    rem_reg, rem_next;
    logic [7:0]    lit_reg, lit_next;
    logic          is_lit_reg, is_lit_next;
    logic [31:0]   target_reg, target_next;
    logic [31:0]   written_reg, written_next;
    logic [31:0]   decoded_reg, decoded_next;
    logic [PW-1:0] pack_reg, pack_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_data_reg, out_data_next;
    logic [3:0]    out_count_reg, out_count_next;
    logic          out_last_reg, out_last_next;
    logic          out_done_reg, out_done_next;
    logic          out_bad_reg, out_bad_next;
    logic [31:0]   out_total_reg, out_total_next;

    logic          slot_free;
    logic          mem_we;
    logic [7:0]    cur_byte;
    logic          wrote;
    logic          last_byte;
    logic          hit_target;
    logic          flush;
    logic [PW-1:0] pack_ins;
    logic [AW:0]   src_diff;
    logic [AW-1:0] src_start;

    assign empty         = !out_valid_reg;
    assign out_data      = 64'(out_data_reg);
    assign out_count     = out_count_reg;
    assign run_last      = out_last_reg;
    assign stream_done   = out_done_reg;
    assign bad_magic     = out_bad_reg;
    assign written_total = out_total_reg;

    assign slot_free = !out_valid_reg || pop;
    assign cur_byte  = is_lit_reg ? lit_reg : rd_data_reg;
    assign wrote     = (decoded_reg >= skip_count);
    assign last_byte = (rem_reg == 9'd1);
    assign hit_target = wrote && (written_reg + 32'd1 == target_reg);
    assign flush = (wrote && (hit_target || cnt_reg + 4'd1 == LANES_C))
                 || (last_byte && (wrote || cnt_reg != 4'd0));

    // copy source wraps around the ring, which need not be a power of two
    assign src_diff  = {1'b0, ptr_reg} - ((AW+1)'(q_cmd.distance) + (AW+1)'(1));
    assign src_start = src_diff[AW] ? AW'(src_diff + DEPTH_W) : src_diff[AW-1:0];

    always_comb begin
        pack_ins = pack_reg;
        for (int i = 0; i < OUT_LANES; i++) begin
            if (4'(i) == cnt_reg)
                pack_ins[8*i +: 8] = cur_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            fin_reg       <= 1'b0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            target_reg    <= '0;
            written_reg   <= '0;
            decoded_reg   <= '0;
            pack_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            ptr_reg       <= ptr_next;
            rem_reg       <= rem_next;
            target_reg    <= target_next;
            written_reg   <= written_next;
            decoded_reg   <= decoded_next;
            pack_reg      <= pack_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        src_reg       <= src_next;
        lit_reg       <= lit_next;
        is_lit_reg    <= is_lit_next;
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
        out_bad_reg   <= out_bad_next;
        out_total_reg <= out_total_next;
    end

    always_ff @(posedge clk) begin
        if (mem_we)
            hist_mem[ptr_reg] <= cur_byte;
        if (state_reg == BK_RD)
            rd_data_reg <= hist_mem[src_reg];
    end

    always_comb begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        ptr_next       = ptr_reg;
        src_next       = src_reg;
        rem_next       = rem_reg;
        lit_next       = lit_reg;
        is_lit_next    = is_lit_reg;
        target_next    = target_reg;
        written_next   = written_reg;
        decoded_next   = decoded_reg;
        pack_next      = pack_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        out_data_next  = out_data_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_bad_next   = out_bad_reg;
        out_total_next = out_total_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    unique case (q_cmd.kind)
                        CMD_START, CMD_BAD: begin
                            if (slot_free || (q_cmd.kind == CMD_START
                                              && q_cmd.target != 32'd0)) begin
                                q_pop        = 1'b1;
                                ptr_next     = '0;
                                written_next = '0;
                                decoded_next = '0;
                                pack_next    = '0;
                                cnt_next     = '0;
                                target_next  = q_cmd.target;
                                fin_next     = 1'b0;
                                // header error or empty target reports one event
                                if (q_cmd.kind == CMD_BAD || q_cmd.target == 32'd0) begin
                                    fin_next       = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_data_next  = '0;
                                    out_count_next = 4'd0;
                                    out_last_next  = 1'b1;
                                    out_done_next  = (q_cmd.kind == CMD_START);
                                    out_bad_next   = (q_cmd.kind == CMD_BAD);
                                    out_total_next = 32'd0;
                                end
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                            if (!fin_reg) begin
                                src_next    = src_start;
                                rem_next    = q_cmd.len;
                                lit_next    = q_cmd.data;
                                is_lit_next = (q_cmd.kind == CMD_LIT);
                                state_next  = (q_cmd.kind == CMD_LIT) ? BK_WR : BK_RD;
                            end
                        end
                    endcase
                end
            end
            BK_RD: begin
                state_next = BK_WR;
            end
            default: begin
                if (!flush || slot_free) begin
                    mem_we   = 1'b1;
                    ptr_next = (ptr_reg == LAST_P) ? '0 : ptr_reg + 1'b1;
                    src_next = (src_reg == LAST_P) ? '0 : src_reg + 1'b1;
                    rem_next = rem_reg - 9'd1;
                    if (decoded_reg != 32'hffff_ffff)
                        decoded_next = decoded_reg + 32'd1;
                    if (wrote) begin
                        written_next = written_reg + 32'd1;
                        pack_next    = pack_ins;
                        cnt_next     = cnt_reg + 4'd1;
                    end
                    if (flush) begin
                        out_valid_next = 1'b1;
                        out_data_next  = wrote ? pack_ins : pack_reg;
                        out_count_next = cnt_reg + 4'(wrote);
                        out_last_next  = last_byte || hit_target;
                        out_done_next  = hit_target;
                        out_bad_next   = 1'b0;
                        out_total_next = written_reg + 32'(wrote);
                        pack_next      = '0;
                        cnt_next       = '0;
                    end
                    if (hit_target) begin
                        fin_next   = 1'b1;
                        state_next = BK_IDLE;
                    end
                    else if (last_byte)
                        state_next = BK_IDLE;
                    else
                        state_next = BK_RD;
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg <= LANES_C)
        else $error("result count above lane count");
    a_bad_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_bad_reg |-> out_count_reg == 4'd0 && out_last_reg)
        else $error("header error result carries data");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("stream done on a result that is not last");
    a_busy_not_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != BK_IDLE |-> !fin_reg)
        else $error("copy running after stream finished");
`endif

endmodule
